[hdl/sdrs_pkg.sv]
// ----------------------------------------------------------------------------
// sdrs_pkg
// shared types and constants of the stable descending record sorter
// ----------------------------------------------------------------------------
package sdrs_pkg;

    localparam int KEY_W   = 7;
    localparam int TAG_W   = 5;
    localparam int TDATA_W = 16;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // what a cell shows its neighbors
    typedef struct packed {
        logic valid;
        logic keep;     // cell valid and stored key >= incoming key, cell holds on insert
        t_rec rec;
    } t_link;

    // per-cycle command broadcast along the chain
    typedef struct packed {
        logic ins;      // insert the broadcast record
        logic drain;    // shift toward cell 0 by one place
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

[hdl/sdrs_cell.sv]
// ----------------------------------------------------------------------------
// sdrs_cell
// one place of the insertion chain, holds a record and a valid bit
// ----------------------------------------------------------------------------
module sdrs_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdrs_pkg::t_cell_ctl  i_ctl,
    input  sdrs_pkg::t_rec       i_new,
    input  sdrs_pkg::t_link      i_prev,
    input  sdrs_pkg::t_link      i_next,
    output sdrs_pkg::t_link      o_link
);

    logic           r_valid;
    sdrs_pkg::t_rec r_rec;
    logic           n_valid;
    sdrs_pkg::t_rec n_rec;
    logic           w_keep;

    // ties stay ahead of the newcomer, which keeps the order stable
    assign w_keep = r_valid && (r_rec.key >= i_new.key);

    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ctl.drain) begin
            n_valid = i_next.valid;
            n_rec   = i_next.rec;
        end else if (i_ctl.ins && !w_keep) begin
            if (i_prev.keep) begin
                n_valid = 1'b1;
                n_rec   = i_new;
            end else begin
                n_valid = i_prev.valid;
                n_rec   = i_prev.rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_link.valid = r_valid;
    assign o_link.keep  = w_keep;
    assign o_link.rec   = r_rec;

endmodule

[hdl/stable_descending_record_sort.sv]
// ----------------------------------------------------------------------------
// stable_descending_record_sort
// insertion-chain sorter, emits a run of records in descending key order
// ----------------------------------------------------------------------------
// Records are taken one item per cycle while loading (tready high) into a
// chain of MAX_ITEMS cells that keeps them sorted at all times: the incoming
// record is broadcast, every cell compares it with its own key, and the cells
// below the insertion point move one place down in the same cycle. Equal keys
// stay in arrival order. Records beyond MAX_ITEMS are dropped. The item marked
// tlast (stored if there is room) starts the output: the chain then shifts
// toward cell 0, one record per cycle into the output register while the
// sink does not stall, with tlast on the final one. Input is held off (tready
// low) from the cycle after the last item until the chain is empty; loading
// resumes while the final record may still wait in the output register.
// Nothing needs a clearing pass after reset.
// ----------------------------------------------------------------------------
module stable_descending_record_sort #(
    parameter int MAX_ITEMS = 32    // 2 to 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [sdrs_pkg::TDATA_W-1:0] i_s_axis_tdata,   // key[6:0], tag[11:7], zero
    input  logic                         i_s_axis_tlast,   // last record of the set
    // output stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [sdrs_pkg::TDATA_W-1:0] o_m_axis_tdata,   // sorted_key[6:0], sorted_tag[11:7], zero
    output logic                         o_m_axis_tlast    // end_of_run
);

    localparam int REC_W = sdrs_pkg::KEY_W + sdrs_pkg::TAG_W;

    sdrs_pkg::t_state    r_state;
    sdrs_pkg::t_state    n_state;
    sdrs_pkg::t_cell_ctl w_ctl;
    sdrs_pkg::t_rec      w_new;
    sdrs_pkg::t_link     w_link [MAX_ITEMS];
    sdrs_pkg::t_link     w_head;   // stands left of cell 0
    sdrs_pkg::t_link     w_tail;   // stands right of the last cell

    logic                r_out_valid;
    sdrs_pkg::t_rec      r_out_rec;
    logic                r_out_last;

    logic                w_in_acc;
    logic                w_full;
    logic                w_load;

    // input item split into its fields
    assign w_new.key = i_s_axis_tdata[sdrs_pkg::KEY_W-1:0];
    assign w_new.tag = i_s_axis_tdata[REC_W-1:sdrs_pkg::KEY_W];

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    // chain holds a prefix of valid cells, so the last one tells full
    assign w_full   = w_link[MAX_ITEMS-1].valid;
    // cell 0 moves into the output register when that is free
    assign w_load   = (r_state == sdrs_pkg::ST_DRAIN) && w_link[0].valid &&
                      (!r_out_valid || i_m_axis_tready);

    assign w_ctl.ins   = w_in_acc && !w_full;
    assign w_ctl.drain = w_load;

    // cell 0 always takes the newcomer if it does not keep its own record
    assign w_head.valid = 1'b0;
    assign w_head.keep  = 1'b1;
    assign w_head.rec   = '0;
    assign w_tail.valid = 1'b0;
    assign w_tail.keep  = 1'b0;
    assign w_tail.rec   = '0;

    // the chain
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        sdrs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_prev  ((g == 0) ? w_head : w_link[(g == 0) ? 0 : g - 1]),
            .i_next  ((g == MAX_ITEMS - 1) ? w_tail
                                           : w_link[(g == MAX_ITEMS - 1) ? g : g + 1]),
            .o_link  (w_link[g])
        );
    end

    // load / drain control
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdrs_pkg::ST_LOAD: begin
                if (w_in_acc && i_s_axis_tlast) begin
                    n_state = sdrs_pkg::ST_DRAIN;
                end
            end
            sdrs_pkg::ST_DRAIN: begin
                // chain empty: every record has reached the output register
                if (!w_link[0].valid) begin
                    n_state = sdrs_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = sdrs_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdrs_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == sdrs_pkg::ST_LOAD);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_rec  <= w_link[0].rec;
            // nothing behind cell 0 means this is the final record
            r_out_last <= !w_link[1].valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(sdrs_pkg::TDATA_W - REC_W){1'b0}},
                              r_out_rec.tag, r_out_rec.key};
    assign o_m_axis_tlast  = r_out_last;

endmodule

[hdl/sdrs_check.sv]
// ----------------------------------------------------------------------------
// sdrs_check
// port-level checks of the record sorter, bound to the top level
// ----------------------------------------------------------------------------
module sdrs_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         i_s_tready,
    input logic                         i_s_tlast,
    input logic                         i_m_tvalid,
    input logic                         i_m_tready,
    input logic [sdrs_pkg::TDATA_W-1:0] i_m_tdata,
    input logic                         i_m_tlast
);

    logic                       r_in_run;
    logic [sdrs_pkg::KEY_W-1:0] r_prev_key;
    logic                       w_out_acc;

    assign w_out_acc = i_m_tvalid && i_m_tready;

    // tracks the key of the previous item of the current run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (w_out_acc) begin
            r_in_run <= !i_m_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_prev_key <= i_m_tdata[sdrs_pkg::KEY_W-1:0];
        end
    end

    // keys leave in descending order within a run
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_in_run) |-> (i_m_tdata[sdrs_pkg::KEY_W-1:0] <= r_prev_key))
        else $error("sorted keys not descending");

    // input is held off once the last item was taken
    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready && i_s_tlast) |=> !i_s_tready)
        else $error("input taken right after last item");

    // a stalled output item holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast)))
        else $error("stalled output item changed");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

endmodule

bind stable_descending_record_sort sdrs_check u_sdrs_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tlast  (i_s_axis_tlast),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);
